@@ design/slsh_pkg.sv @@
// Shared types and constants for the solar load switch with hysteresis.
// Holds field widths, register map, reset values and the mean divider constants.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package slsh_pkg;

  // Light samples summed per block are WINDOW + 1.
  localparam int unsigned WINDOW     = 200;

  localparam int unsigned MV_W       = 15;
  localparam int unsigned LIGHT_W    = 12;
  localparam int unsigned CAUSE_W    = 2;
  localparam int unsigned MOTION_W   = 16;
  localparam int unsigned SUM_W      = 20;
  localparam int unsigned CNT_W      = $clog2(WINDOW + 2);

  // The block mean divides by WINDOW + 1. The reciprocal is rounded up, which
  // is exact for any 20-bit sum because the rounding error times the sum stays
  // below 2**MEAN_SHIFT / DIVISOR.
  localparam int unsigned DIVISOR    = WINDOW + 1;
  localparam int unsigned MEAN_SHIFT = 32;
  localparam int unsigned RECIP_W    = 32;
  localparam logic [RECIP_W-1:0] MEAN_RECIP =
    RECIP_W'(((64'd1 << MEAN_SHIFT) / DIVISOR) + 64'd1);

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_ON_THR    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_OFF_THR   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LIGHT_THR = 2'd2;

  localparam logic [MV_W-1:0]    ON_THR_RST    = 15'd14500;
  localparam logic [MV_W-1:0]    OFF_THR_RST   = 15'd13500;
  localparam logic [LIGHT_W-1:0] LIGHT_THR_RST = 12'd3000;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_NONE  = 2'd0,
    CAUSE_LOW_V = 2'd1,
    CAUSE_DARK  = 2'd2
  } cause_e;

  typedef struct packed {
    logic [MV_W-1:0]    on_thr_mv;
    logic [MV_W-1:0]    off_thr_mv;
    logic [LIGHT_W-1:0] light_thr;
  } cfg_t;

  typedef struct packed {
    logic [MV_W-1:0]    bus_mv;
    logic [LIGHT_W-1:0] light_level;
    logic               motion;
  } sample_t;

  typedef struct packed {
    logic                load_on;
    logic [CAUSE_W-1:0]  stop_cause;
    logic [LIGHT_W-1:0]  light_mean;
    logic [MOTION_W-1:0] motion_total;
  } result_t;

endpackage

`default_nettype wire

@@ design/slsh_if.sv @@
// Valid/ready channel interfaces for measurement input and result output.
// Depends on slsh_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface slsh_in_if;
  import slsh_pkg::*;

  logic               valid;
  logic               ready;
  logic [MV_W-1:0]    bus_mv;
  logic [LIGHT_W-1:0] light_level;
  logic               motion;

  modport source (output valid, output bus_mv, output light_level, output motion,
                  input ready);
  modport sink (input valid, input bus_mv, input light_level, input motion,
                output ready);
endinterface

interface slsh_out_if;
  import slsh_pkg::*;

  logic                valid;
  logic                ready;
  logic                load_on;
  logic [CAUSE_W-1:0]  stop_cause;
  logic [LIGHT_W-1:0]  light_mean;
  logic [MOTION_W-1:0] motion_total;

  modport source (output valid, output load_on, output stop_cause, output light_mean,
                  output motion_total, input ready);
  modport sink (input valid, input load_on, input stop_cause, input light_mean,
                input motion_total, output ready);
endinterface

`default_nettype wire

@@ design/slsh_apb_regs.sv @@
// APB-style register file for the three thresholds.
// Depends on slsh_pkg for the register map, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module slsh_apb_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [slsh_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [slsh_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [slsh_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output slsh_pkg::cfg_t                        cfg_o
);
  import slsh_pkg::*;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;
  cfg_t                 cfg_q;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[REG_IDX_W+1:2];
  assign cfg_o   = cfg_q;

  // Register writes complete in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_thr_mv  <= ON_THR_RST;
      cfg_q.off_thr_mv <= OFF_THR_RST;
      cfg_q.light_thr  <= LIGHT_THR_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ON_THR:    cfg_q.on_thr_mv  <= pwdata[MV_W-1:0];
        REG_OFF_THR:   cfg_q.off_thr_mv <= pwdata[MV_W-1:0];
        REG_LIGHT_THR: cfg_q.light_thr  <= pwdata[LIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back; index 3 (0xC) reads as zero, and paddr[1:0] are ignored.
  always_comb begin
    unique case (reg_idx)
      REG_ON_THR:    prdata = APB_DATA_W'(cfg_q.on_thr_mv);
      REG_OFF_THR:   prdata = APB_DATA_W'(cfg_q.off_thr_mv);
      REG_LIGHT_THR: prdata = APB_DATA_W'(cfg_q.light_thr);
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ design/slsh_mean_div.sv @@
// Block mean of the light sum: division by WINDOW + 1 through a rounded-up
// reciprocal multiply. Depends on slsh_pkg for MEAN_RECIP and widths.
`timescale 1ns / 1ps
`default_nettype none

module slsh_mean_div (
  input  wire logic [slsh_pkg::SUM_W-1:0]   sum_i,
  output logic      [slsh_pkg::LIGHT_W-1:0] mean_o
);
  import slsh_pkg::*;

  logic [SUM_W+RECIP_W-1:0] prod;

  // One 20 x 32 multiply; the quotient sits above the fraction bits.
  assign prod   = (SUM_W+RECIP_W)'(sum_i) * (SUM_W+RECIP_W)'(MEAN_RECIP);
  assign mean_o = prod[MEAN_SHIFT +: LIGHT_W];

endmodule

`default_nettype wire

@@ design/slsh_core_pipe.sv @@
// Sample register, switch state and result register of the load switch.
// Depends on slsh_pkg and instantiates slsh_mean_div.
`timescale 1ns / 1ps
`default_nettype none

module slsh_core_pipe (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire slsh_pkg::cfg_t    cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire slsh_pkg::sample_t in_sample_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output slsh_pkg::result_t      out_result_o
);
  import slsh_pkg::*;

  logic                smp_valid_q;
  sample_t             smp_q;
  logic                res_valid_q;
  result_t             res_q;
  logic                advance;

  logic                powered_q, powered_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [LIGHT_W-1:0]  avg_q, avg_d;
  logic [MOTION_W-1:0] motion_q, motion_d;
  cause_e              cause_q, cause_d;
  logic [LIGHT_W-1:0]  mean;
  logic                low_v;
  logic                dark;

  // A sample moves on when the result register is empty or being drained.
  assign advance      = smp_valid_q & (~res_valid_q | out_ready_i);
  assign in_ready_o   = ~smp_valid_q | advance;
  assign out_valid_o  = res_valid_q;
  assign out_result_o = res_q;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      smp_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      smp_q <= in_sample_i;
    end
  end

  slsh_mean_div u_mean_div (
    .sum_i  (sum_q),
    .mean_o (mean)
  );

  // Next switch state for the sample in the input register.
  always_comb begin
    powered_d = powered_q;
    sum_d     = sum_q;
    count_d   = count_q;
    avg_d     = avg_q;
    motion_d  = motion_q;
    cause_d   = cause_q;
    low_v     = 1'b0;
    dark      = 1'b0;
    if (!powered_q) begin
      // The switch-on sample only turns the load on and clears the block.
      if (smp_q.bus_mv > cfg_i.on_thr_mv && smp_q.light_level < cfg_i.light_thr) begin
        powered_d = 1'b1;
        sum_d     = '0;
        count_d   = '0;
        avg_d     = '0;
        motion_d  = '0;
      end
    end else begin
      // Accumulate a full block, then spend one sample taking its mean.
      if (count_q <= CNT_W'(WINDOW)) begin
        sum_d   = sum_q + SUM_W'(smp_q.light_level);
        count_d = count_q + CNT_W'(1);
      end else begin
        avg_d   = mean;
        sum_d   = '0;
        count_d = '0;
      end
      if (smp_q.motion && motion_q != '1) begin
        motion_d = motion_q + MOTION_W'(1);
      end
      low_v = smp_q.bus_mv <= cfg_i.off_thr_mv;
      dark  = avg_d >= cfg_i.light_thr;
      // A dark average outranks low voltage as the recorded reason.
      priority if (dark) begin
        cause_d = CAUSE_DARK;
      end else if (low_v) begin
        cause_d = CAUSE_LOW_V;
      end else begin
        cause_d = cause_q;
      end
      if (low_v || dark) begin
        powered_d = 1'b0;
      end
    end
  end

  // Switch state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      powered_q <= 1'b0;
      sum_q     <= '0;
      count_q   <= '0;
      avg_q     <= '0;
      motion_q  <= '0;
      cause_q   <= CAUSE_NONE;
    end else if (advance) begin
      powered_q <= powered_d;
      sum_q     <= sum_d;
      count_q   <= count_d;
      avg_q     <= avg_d;
      motion_q  <= motion_d;
      cause_q   <= cause_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q.load_on      <= powered_d;
      res_q.stop_cause   <= cause_d;
      res_q.light_mean   <= avg_d;
      res_q.motion_total <= motion_d;
    end
  end

endmodule

`default_nettype wire

@@ design/solar_load_switch_hysteresis_core.sv @@
// Top level of the solar load switch with voltage hysteresis and light cutoff.
// Depends on slsh_pkg, slsh_if, slsh_apb_regs and slsh_core_pipe.
//
//   Channel   Direction  Handshake                Content
//   in_if     sink       valid/ready              bus_mv, light_level, motion
//   out_if    source     valid/ready              load_on, stop_cause, light_mean,
//                                                 motion_total
//   APB       slave      psel/penable, pready=1   thresholds at 0x0, 0x4, 0x8
//
// One measurement is taken per cycle while out_if is not stalled; each result
// passes the input register, then the result register. The state update, with
// its reciprocal multiply for the block mean, fits between those registers.
// A stalled result holds while one more measurement waits in the input register.
// Reset clears the switch state and loads the default thresholds; no clearing
// pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module solar_load_switch_hysteresis_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  slsh_in_if.sink                               in_if,
  slsh_out_if.source                            out_if,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [slsh_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [slsh_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [slsh_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready
);
  import slsh_pkg::*;

  cfg_t    cfg;
  sample_t sample;
  result_t result;

  assign sample.bus_mv      = in_if.bus_mv;
  assign sample.light_level = in_if.light_level;
  assign sample.motion      = in_if.motion;

  assign out_if.load_on      = result.load_on;
  assign out_if.stop_cause   = result.stop_cause;
  assign out_if.light_mean   = result.light_mean;
  assign out_if.motion_total = result.motion_total;

  slsh_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  slsh_core_pipe u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_if.valid),
    .in_ready_o   (in_if.ready),
    .in_sample_i  (sample),
    .out_valid_o  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .out_result_o (result)
  );

endmodule

`default_nettype wire

@@ design/slsh_checker.sv @@
// Port-level checks on the result stream of the load switch, bound to the top.
// Depends on slsh_pkg and solar_load_switch_hysteresis_core.
`timescale 1ns / 1ps
`default_nettype none

module slsh_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic                          load_on_i,
  input wire logic [slsh_pkg::CAUSE_W-1:0]  stop_cause_i,
  input wire logic [slsh_pkg::LIGHT_W-1:0]  light_mean_i,
  input wire logic [slsh_pkg::MOTION_W-1:0] motion_total_i
);
  import slsh_pkg::*;

  logic                out_acc;
  logic                seen_q;
  logic                last_load_q;
  logic [CAUSE_W-1:0]  last_cause_q;
  logic [MOTION_W-1:0] last_motion_q;

  assign out_acc = out_valid_i & out_ready_i;

  // Remember the previous delivered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q        <= 1'b0;
      last_load_q   <= 1'b0;
      last_cause_q  <= '0;
      last_motion_q <= '0;
    end else if (out_acc) begin
      seen_q        <= 1'b1;
      last_load_q   <= load_on_i;
      last_cause_q  <= stop_cause_i;
      last_motion_q <= motion_total_i;
    end
  end

  // A stalled result stays put.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(load_on_i) &&
      $stable(stop_cause_i) && $stable(light_mean_i) && $stable(motion_total_i))
    else $error("result changed while stalled");

  // While the load stays off, the motion count is frozen.
  a_off_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q && !last_load_q && !load_on_i |-> motion_total_i == last_motion_q)
    else $error("motion count moved while load off");

  // While the load was on, the motion count never falls.
  a_motion_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q && last_load_q |-> motion_total_i >= last_motion_q)
    else $error("motion count decreased while load on");

  // Once an off reason is recorded it never returns to none.
  a_cause_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q && last_cause_q != CAUSE_NONE |-> stop_cause_i != CAUSE_NONE)
    else $error("off reason was cleared");

endmodule

bind solar_load_switch_hysteresis_core slsh_checker u_slsh_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_if.valid),
  .out_ready_i    (out_if.ready),
  .load_on_i      (out_if.load_on),
  .stop_cause_i   (out_if.stop_cause),
  .light_mean_i   (out_if.light_mean),
  .motion_total_i (out_if.motion_total)
);

`default_nettype wire
